// ----- hw/rtl/srd_pkg.sv -----
// Shared types and defaults for the signed restoring divider.
// No dependencies; every other file imports this package.
package srd_pkg;

    localparam int DEFAULT_WIDTH = 32;

    // Sign and error flags that ride along with each division through the array
    typedef struct packed {
        logic a_neg;
        logic b_neg;
        logic div_zero;
    } t_flags;

endpackage

// ----- hw/rtl/srd_if.sv -----
// Valid/ready channel interfaces for the divider's operand and result sides.
// Depends on srd_pkg for the default data width.
interface srd_in_if import srd_pkg::*; #(
    parameter int WIDTH = DEFAULT_WIDTH
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] dividend;
    logic [WIDTH-1:0] divisor;

    modport source (output valid, output dividend, output divisor, input ready);
    modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

interface srd_out_if import srd_pkg::*; #(
    parameter int WIDTH = DEFAULT_WIDTH
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] quotient;
    logic [WIDTH-1:0] remainder;
    logic             divide_by_zero;

    modport source (output valid, output quotient, output remainder,
                    output divide_by_zero, input ready);
    modport sink   (input valid, input quotient, input remainder,
                    input divide_by_zero, output ready);
endinterface

// ----- hw/rtl/srd_front.sv -----
// Input stage: registers operand magnitudes, signs and the zero-divisor flag.
// Depends on srd_pkg for t_flags.
module srd_front import srd_pkg::*; #(
    parameter int WIDTH = DEFAULT_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_aq,
    output logic [WIDTH-1:0] o_nb,
    output t_flags           o_flags
);

    localparam logic [WIDTH-1:0] ONE = {{(WIDTH-1){1'b0}}, 1'b1};

    logic             r_valid;
    logic [WIDTH-1:0] r_aq, n_aq;
    logic [WIDTH-1:0] r_nb, n_nb;
    t_flags           r_flags, n_flags;
    logic             w_load;

    assign o_ready = !r_valid || i_ready;
    assign w_load  = i_valid && o_ready;

    always_comb begin
        n_flags.a_neg    = i_dividend[WIDTH-1];
        n_flags.b_neg    = i_divisor[WIDTH-1];
        n_flags.div_zero = (i_divisor == '0);
        n_aq = i_dividend[WIDTH-1] ? (~i_dividend + ONE) : i_dividend;
        n_nb = i_divisor[WIDTH-1]  ? (~i_divisor + ONE)  : i_divisor;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_aq    <= n_aq;
            r_nb    <= n_nb;
            r_flags <= n_flags;
        end
    end

    assign o_valid = r_valid;
    assign o_aq    = r_aq;
    assign o_nb    = r_nb;
    assign o_flags = r_flags;

endmodule

// ----- hw/rtl/srd_cell.sv -----
// One restoring-division step: shift in a dividend bit, trial subtract, keep or restore.
// Depends on srd_pkg for t_flags.
module srd_cell import srd_pkg::*; #(
    parameter int WIDTH = DEFAULT_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_r,
    input  logic [WIDTH-1:0] i_aq,
    input  logic [WIDTH-1:0] i_nb,
    input  t_flags           i_flags,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_r,
    output logic [WIDTH-1:0] o_aq,
    output logic [WIDTH-1:0] o_nb,
    output t_flags           o_flags
);

    logic             r_valid;
    logic [WIDTH-1:0] r_r, n_r;
    logic [WIDTH-1:0] r_aq, n_aq;
    logic [WIDTH-1:0] r_nb;
    t_flags           r_flags;
    logic [WIDTH-1:0] w_trial;
    logic             w_ge;
    logic             w_load;

    assign o_ready = !r_valid || i_ready;
    assign w_load  = i_valid && o_ready;

    // Remainder stays below a nonzero divisor's magnitude, so its top bit is always clear.
    // The dividend shifts out of aq from the top while quotient bits fill the bottom.
    always_comb begin
        w_trial = {i_r[WIDTH-2:0], i_aq[WIDTH-1]};
        w_ge    = (w_trial >= i_nb);
        n_r     = w_ge ? (w_trial - i_nb) : w_trial;
        n_aq    = {i_aq[WIDTH-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_r     <= n_r;
            r_aq    <= n_aq;
            r_nb    <= i_nb;
            r_flags <= i_flags;
        end
    end

    assign o_valid = r_valid;
    assign o_r     = r_r;
    assign o_aq    = r_aq;
    assign o_nb    = r_nb;
    assign o_flags = r_flags;

endmodule

// ----- hw/rtl/srd_back.sv -----
// Output stage: applies result signs, forces zeros on divide by zero, holds the result.
// Depends on srd_pkg for t_flags.
module srd_back import srd_pkg::*; #(
    parameter int WIDTH = DEFAULT_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_r,
    input  logic [WIDTH-1:0] i_q,
    input  t_flags           i_flags,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_quotient,
    output logic [WIDTH-1:0] o_remainder,
    output logic             o_divide_by_zero
);

    localparam logic [WIDTH-1:0] ONE = {{(WIDTH-1){1'b0}}, 1'b1};

    logic             r_valid;
    logic [WIDTH-1:0] r_quotient, n_quotient;
    logic [WIDTH-1:0] r_remainder, n_remainder;
    logic             r_div_zero;
    logic             w_load;

    assign o_ready = !r_valid || i_ready;
    assign w_load  = i_valid && o_ready;

    always_comb begin
        n_quotient  = (i_flags.a_neg ^ i_flags.b_neg) ? (~i_q + ONE) : i_q;
        n_remainder = i_flags.a_neg ? (~i_r + ONE) : i_r;
        if (i_flags.div_zero) begin
            n_quotient  = '0;
            n_remainder = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_quotient  <= n_quotient;
            r_remainder <= n_remainder;
            r_div_zero  <= i_flags.div_zero;
        end
    end

    assign o_valid          = r_valid;
    assign o_quotient       = r_quotient;
    assign o_remainder      = r_remainder;
    assign o_divide_by_zero = r_div_zero;

endmodule

// ----- hw/rtl/signed_restoring_divider.sv -----
// Signed restoring divider: front stage, a chain of WIDTH step cells, back stage.
// Accepts one division per cycle while the result side does not stall, set by one
// compare-and-subtract cell per quotient bit. Every stage is elastic, so bubbles
// close up while the result side stalls. Synchronous active-low reset clears all
// stage valid bits; data registers are not reset. Depends on srd_pkg and srd_if.
module signed_restoring_divider import srd_pkg::*; #(
    parameter int WIDTH = DEFAULT_WIDTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    srd_in_if.sink    i_in,
    srd_out_if.source o_out
);

    logic             w_valid [0:WIDTH];
    logic             w_ready [0:WIDTH];
    logic [WIDTH-1:0] w_r     [0:WIDTH];
    logic [WIDTH-1:0] w_aq    [0:WIDTH];
    logic [WIDTH-1:0] w_nb    [0:WIDTH];
    t_flags           w_flags [0:WIDTH];

    srd_front #(.WIDTH(WIDTH)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in.valid),
        .o_ready    (i_in.ready),
        .i_dividend (i_in.dividend),
        .i_divisor  (i_in.divisor),
        .o_valid    (w_valid[0]),
        .i_ready    (w_ready[0]),
        .o_aq       (w_aq[0]),
        .o_nb       (w_nb[0]),
        .o_flags    (w_flags[0])
    );

    assign w_r[0] = '0;

    for (genvar g = 0; g < WIDTH; g++) begin : g_cell
        srd_cell #(.WIDTH(WIDTH)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_r     (w_r[g]),
            .i_aq    (w_aq[g]),
            .i_nb    (w_nb[g]),
            .i_flags (w_flags[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_r     (w_r[g+1]),
            .o_aq    (w_aq[g+1]),
            .o_nb    (w_nb[g+1]),
            .o_flags (w_flags[g+1])
        );
    end

    srd_back #(.WIDTH(WIDTH)) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (w_valid[WIDTH]),
        .o_ready          (w_ready[WIDTH]),
        .i_r              (w_r[WIDTH]),
        .i_q              (w_aq[WIDTH]),
        .i_flags          (w_flags[WIDTH]),
        .o_valid          (o_out.valid),
        .i_ready          (o_out.ready),
        .o_quotient       (o_out.quotient),
        .o_remainder      (o_out.remainder),
        .o_divide_by_zero (o_out.divide_by_zero)
    );

endmodule
